>>> rtl/bplm_pkg.sv
`default_nettype none
package bplm_pkg;

	localparam int FRAME_COUNT_DEF  = 16;
	localparam int PIN_BITS_DEF     = 8;
	localparam int PAGE_ID_BITS_DEF = 32;

	// Field widths fixed by the stream format
	localparam int OP_W     = 3;
	localparam int KIND_W   = 2;
	localparam int FRAME_W  = 4;
	localparam int PAGEIO_W = 32;
	localparam int ERR_W    = 3;

	typedef enum logic [OP_W-1:0] {
		OP_FETCH     = 3'd0,
		OP_UNPIN     = 3'd1,
		OP_NEW       = 3'd2,
		OP_FLUSH     = 3'd3,
		OP_FLUSH_ALL = 3'd4
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		K_GRANT = 2'd0,
		K_WB    = 2'd1,
		K_DONE  = 2'd2,
		K_ERR   = 2'd3
	} kind_t;

	typedef enum logic [ERR_W-1:0] {
		E_NONE     = 3'd0,
		E_ALLPIN   = 3'd1,
		E_NOTIN    = 3'd2,
		E_NOTPIN   = 3'd3,
		E_OVERFLOW = 3'd4
	} err_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOOK,
		S_DECIDE,
		S_SHIFT,
		S_PLACE,
		S_WALK,
		S_EMIT,
		S_WAIT
	} state_t;

	// One result as held in the output register
	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [FRAME_W-1:0]  frame;
		logic [PAGEIO_W-1:0] page_id_out;
		logic                needs_read;
		logic                needs_zero;
		logic [ERR_W-1:0]    error;
		logic                last;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/bplm_tag_match.sv
`default_nettype none
// Parallel tag compare over all frames, registered result
module bplm_tag_match #(
	parameter int FRAME_COUNT  = bplm_pkg::FRAME_COUNT_DEF,
	parameter int PAGE_ID_BITS = bplm_pkg::PAGE_ID_BITS_DEF,
	localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     start,
	input  wire [PAGE_ID_BITS-1:0]                  key,
	input  wire [FRAME_COUNT-1:0]                   valid,
	input  wire [FRAME_COUNT-1:0][PAGE_ID_BITS-1:0] tags,
	output logic                                    hit_q,
	output logic [FW-1:0]                           hit_idx_q
);

	logic          hit;
	logic [FW-1:0] idx;

	// Find the lowest matching valid frame
	always_comb begin
		hit = 1'b0;
		idx = '0;
		for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
			if (valid[i] && tags[i] == key) begin
				hit = 1'b1;
				idx = FW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (start) begin
			hit_q <= hit;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hit_idx_q <= idx;
		end
	end

endmodule
`default_nettype wire

>>> rtl/buffer_pool_lru_manager_unit.sv
`default_nettype none
// Buffer pool frame manager: tag lookup, pin counts and LRU victim choice.
// s_tready is high only while the block is idle and stays low until the final
// result of a request has been taken. A request with one result and no queue
// change passes through lookup, decide, load the result, hand it over, idle.
// Taking a frame out of the LRU queue (a miss, a new page, or a hit on an
// unpinned frame) scans the whole queue, one slot per cycle, and a miss
// then places the page in the victim frame. A write-back result comes ahead
// of a grant or done when the frame is dirty. Flush all walks every frame one
// per cycle while no write-back is waiting, emits a write-back for each dirty
// frame and ends with a done. A result is held while m_tready is low.
// Results carry tlast on the final one of a request.
module buffer_pool_lru_manager_unit #(
	parameter int FRAME_COUNT  = bplm_pkg::FRAME_COUNT_DEF,
	parameter int PIN_BITS     = bplm_pkg::PIN_BITS_DEF,
	parameter int PAGE_ID_BITS = bplm_pkg::PAGE_ID_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,   // op[2:0], page_id[34:3], modified[35]
	input  wire         m_tready,
	output logic        m_tvalid,
	output logic [47:0] m_tdata,   // kind[1:0], frame[5:2], page_id_out[37:6],
	                               // needs_read[38], needs_zero[39], error[42:40]
	output logic        m_tlast
);

	localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
	localparam int CW = $clog2(FRAME_COUNT + 1);
	localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

	bplm_pkg::state_t state_q, state_d;

	logic [FRAME_COUNT-1:0]                   valid_q, dirty_q, in_lru_q;
	logic [FRAME_COUNT-1:0][PAGE_ID_BITS-1:0] page_q;
	logic [FRAME_COUNT-1:0][PIN_BITS-1:0]     pins_q;
	logic [FRAME_COUNT-1:0][FW-1:0]           order_q;
	logic [CW-1:0]                            count_q;

	logic [2:0]              op_q;
	logic [PAGE_ID_BITS-1:0] key_q;
	logic                    mod_q;
	logic [FW-1:0]           f_q;       // frame acted on
	logic [CW-1:0]           pos_q;     // queue scan position / walk index
	logic                    found_q;   // frame seen during the queue scan
	logic                    grant_q;   // second result pending after write-back
	bplm_pkg::result_t       res_q;
	logic                    hit;
	logic [FW-1:0]           hit_idx;

	logic          accept;
	logic          is_pin;
	logic          shift_end;
	logic [FW-1:0] head;
	logic [FW-1:0] walk;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == bplm_pkg::S_IDLE);
	assign is_pin    = (op_q == bplm_pkg::OP_FETCH || op_q == bplm_pkg::OP_NEW);
	assign shift_end = (pos_q + CW'(1) >= count_q);
	assign head      = order_q[0];
	assign walk      = pos_q[FW-1:0];

	bplm_tag_match #(.FRAME_COUNT(FRAME_COUNT), .PAGE_ID_BITS(PAGE_ID_BITS)) u_match (
		.clk(clk), .arst_n(arst_n), .start(state_q == bplm_pkg::S_LOOK),
		.key(key_q), .valid(valid_q), .tags(page_q),
		.hit_q(hit), .hit_idx_q(hit_idx)
	);

	function automatic bplm_pkg::result_t mk(input logic [1:0] k, input logic [FW-1:0] f,
			input logic [PAGE_ID_BITS-1:0] p, input logic rd, input logic zf,
			input logic [2:0] e, input logic l);
		bplm_pkg::result_t r;
		r.kind        = k;
		r.frame       = bplm_pkg::FRAME_W'(32'(f));
		r.page_id_out = bplm_pkg::PAGEIO_W'(64'(p));
		r.needs_read  = rd;
		r.needs_zero  = zf;
		r.error       = e;
		r.last        = l;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= bplm_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bplm_pkg::S_IDLE:   if (accept) state_d = bplm_pkg::S_LOOK;
			bplm_pkg::S_LOOK:   state_d = bplm_pkg::S_DECIDE;
			bplm_pkg::S_DECIDE: begin
				if (op_q == bplm_pkg::OP_FLUSH_ALL) state_d = bplm_pkg::S_WALK;
				else if (is_pin && !hit && count_q != '0) state_d = bplm_pkg::S_SHIFT;
				else if (is_pin && hit && pins_q[hit_idx] == '0) state_d = bplm_pkg::S_SHIFT;
				else state_d = bplm_pkg::S_EMIT;
			end
			bplm_pkg::S_SHIFT: begin
				if (shift_end) state_d = hit ? bplm_pkg::S_EMIT : bplm_pkg::S_PLACE;
			end
			bplm_pkg::S_PLACE:  state_d = bplm_pkg::S_EMIT;
			bplm_pkg::S_WALK: begin
				if (pos_q == CW'(FRAME_COUNT) || (valid_q[walk] && dirty_q[walk]))
					state_d = bplm_pkg::S_WAIT;
			end
			bplm_pkg::S_EMIT:   state_d = bplm_pkg::S_WAIT;
			bplm_pkg::S_WAIT: begin
				if (m_tready) begin
					if (res_q.last) state_d = bplm_pkg::S_IDLE;
					else if (grant_q) state_d = bplm_pkg::S_EMIT;
					else state_d = bplm_pkg::S_WALK;
				end
			end
			default:            state_d = bplm_pkg::S_IDLE;
		endcase
	end

	// State updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			dirty_q  <= '0;
			pins_q   <= '0;
			page_q   <= '0;
			in_lru_q <= '1;
			count_q  <= CW'(FRAME_COUNT);
			for (int i = 0; i < FRAME_COUNT; i++) order_q[i] <= FW'(i);
			m_tvalid <= 1'b0;
			grant_q  <= 1'b0;
			found_q  <= 1'b0;
			pos_q    <= '0;
			f_q      <= '0;
			res_q    <= '0;
		end else begin
			unique case (state_q)
				bplm_pkg::S_IDLE: begin
					grant_q <= 1'b0;
					found_q <= 1'b0;
					pos_q   <= '0;
				end
				bplm_pkg::S_LOOK: ;
				bplm_pkg::S_DECIDE: begin
					pos_q   <= '0;
					found_q <= 1'b0;
					if (is_pin) begin
						if (hit) begin
							f_q <= hit_idx;
							if (pins_q[hit_idx] == PIN_MAX) begin
								res_q <= mk(bplm_pkg::K_ERR, '0, key_q, 1'b0, 1'b0,
									bplm_pkg::E_OVERFLOW, 1'b1);
							end else begin
								pins_q[hit_idx] <= pins_q[hit_idx] + PIN_BITS'(1);
								if (op_q == bplm_pkg::OP_NEW) dirty_q[hit_idx] <= 1'b0;
								res_q <= mk(bplm_pkg::K_GRANT, hit_idx, key_q, 1'b0,
									op_q == bplm_pkg::OP_NEW, bplm_pkg::E_NONE, 1'b1);
							end
						end else if (count_q == '0) begin
							res_q <= mk(bplm_pkg::K_ERR, '0, key_q, 1'b0, 1'b0,
								bplm_pkg::E_ALLPIN, 1'b1);
						end else begin
							f_q <= head;
						end
					end else if (op_q == bplm_pkg::OP_UNPIN) begin
						if (!hit) begin
							res_q <= mk(bplm_pkg::K_ERR, '0, key_q, 1'b0, 1'b0,
								bplm_pkg::E_NOTIN, 1'b1);
						end else if (pins_q[hit_idx] == '0) begin
							res_q <= mk(bplm_pkg::K_ERR, '0, key_q, 1'b0, 1'b0,
								bplm_pkg::E_NOTPIN, 1'b1);
						end else begin
							if (mod_q) dirty_q[hit_idx] <= 1'b1;
							pins_q[hit_idx] <= pins_q[hit_idx] - PIN_BITS'(1);
							if (pins_q[hit_idx] == PIN_BITS'(1) && !in_lru_q[hit_idx]
									&& count_q < CW'(FRAME_COUNT)) begin
								order_q[count_q[FW-1:0]] <= hit_idx;
								count_q <= count_q + CW'(1);
								in_lru_q[hit_idx] <= 1'b1;
							end
							res_q <= mk(bplm_pkg::K_DONE, hit_idx, key_q, 1'b0, 1'b0,
								bplm_pkg::E_NONE, 1'b1);
						end
					end else if (op_q == bplm_pkg::OP_FLUSH) begin
						if (hit && dirty_q[hit_idx]) begin
							dirty_q[hit_idx] <= 1'b0;
							grant_q <= 1'b1;
							f_q <= hit_idx;
							res_q <= mk(bplm_pkg::K_WB, hit_idx, key_q, 1'b0, 1'b0,
								bplm_pkg::E_NONE, 1'b0);
						end else begin
							res_q <= mk(bplm_pkg::K_DONE, hit ? hit_idx : '0, key_q, 1'b0,
								1'b0, bplm_pkg::E_NONE, 1'b1);
						end
					end else begin
						res_q <= mk(bplm_pkg::K_DONE, '0, key_q, 1'b0, 1'b0,
							bplm_pkg::E_NONE, 1'b1);
					end
				end
				// Scan the queue one slot a cycle, closing the gap behind f_q
				bplm_pkg::S_SHIFT: begin
					if (!shift_end) begin
						if (found_q || order_q[walk] == f_q)
							order_q[walk] <= order_q[FW'(pos_q + CW'(1))];
						found_q <= found_q || order_q[walk] == f_q;
						pos_q   <= pos_q + CW'(1);
					end else begin
						count_q       <= count_q - CW'(1);
						in_lru_q[f_q] <= 1'b0;
					end
				end
				// Victim taken: request write-back if dirty, then grant
				bplm_pkg::S_PLACE: begin
					if (valid_q[f_q] && dirty_q[f_q]) begin
						res_q <= mk(bplm_pkg::K_WB, f_q, page_q[f_q], 1'b0, 1'b0,
							bplm_pkg::E_NONE, 1'b0);
						grant_q <= 1'b1;
					end else begin
						res_q <= mk(bplm_pkg::K_GRANT, f_q, key_q,
							op_q != bplm_pkg::OP_NEW, op_q == bplm_pkg::OP_NEW,
							bplm_pkg::E_NONE, 1'b1);
					end
					valid_q[f_q] <= 1'b1;
					page_q[f_q]  <= key_q;
					dirty_q[f_q] <= 1'b0;
					pins_q[f_q]  <= PIN_BITS'(1);
				end
				// Walk every frame, emitting a write-back for each dirty one, then finish with done
				bplm_pkg::S_WALK: begin
					if (pos_q == CW'(FRAME_COUNT)) begin
						res_q <= mk(bplm_pkg::K_DONE, '0, key_q, 1'b0, 1'b0,
							bplm_pkg::E_NONE, 1'b1);
						m_tvalid <= 1'b1;
					end else begin
						if (valid_q[walk] && dirty_q[walk]) begin
							dirty_q[walk] <= 1'b0;
							res_q <= mk(bplm_pkg::K_WB, walk, page_q[walk], 1'b0, 1'b0,
								bplm_pkg::E_NONE, 1'b0);
							m_tvalid <= 1'b1;
						end
						pos_q <= pos_q + CW'(1);
					end
				end
				bplm_pkg::S_EMIT: m_tvalid <= 1'b1;
				bplm_pkg::S_WAIT: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						if (grant_q) begin
							grant_q <= 1'b0;
							if (op_q == bplm_pkg::OP_FLUSH)
								res_q <= mk(bplm_pkg::K_DONE, f_q, key_q, 1'b0, 1'b0,
									bplm_pkg::E_NONE, 1'b1);
							else
								res_q <= mk(bplm_pkg::K_GRANT, f_q, key_q,
									op_q != bplm_pkg::OP_NEW, op_q == bplm_pkg::OP_NEW,
									bplm_pkg::E_NONE, 1'b1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Capture request
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tdata[2:0];
			key_q <= PAGE_ID_BITS'(s_tdata[34:3]);
			mod_q <= s_tdata[35];
		end
	end

	assign m_tdata = {5'b0, res_q.error, res_q.needs_zero, res_q.needs_read,
		res_q.page_id_out, res_q.frame, res_q.kind};
	assign m_tlast = res_q.last;

	ap_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(FRAME_COUNT)) else $error("queue count above frames");
	ap_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("ready during output");
	ap_lru: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(in_lru_q) == 32'(count_q)) else $error("queue membership mismatch");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while waiting");

endmodule
`default_nettype wire
